// ===== hw/rtl/snrp_pkg.sv =====
package snrp_pkg;

  localparam int GradWidth  = 24;
  localparam int CoordWidth = 12;
  localparam int MagWidth   = GradWidth;
  localparam int SqWidth    = 2 * MagWidth;
  localparam int SumWidth   = SqWidth + 2;
  // squared sum scaled by 65536 for 8 fraction bits of length
  localparam int RadWidth   = SumWidth + 16;
  localparam int RootWidth  = RadWidth / 2;
  localparam int RootSteps  = RootWidth;
  // numerator 256*g + len is at most 512*len
  localparam int NumWidth   = RootWidth + 10;
  localparam int ProdWidth  = NumWidth + 8;
  localparam int DivSteps   = 9;
  localparam int InWidth    = 3 * GradWidth + 2 * CoordWidth;
  localparam int InBytes    = (InWidth + 7) / 8;
  localparam int OutWidth   = 2 * CoordWidth + 32;
  localparam int OutBytes   = (OutWidth + 7) / 8;
  localparam logic [7:0] AlphaByte = 8'hff;
  localparam logic [7:0] ZeroByte  = 8'd127;

  typedef logic [CoordWidth-1:0] coord_t;

  // root work state travelling down the pipeline
  typedef struct packed {
    logic [RadWidth-1:0]   rad;
    logic [RootWidth+1:0]  rem;
    logic [RootWidth-1:0]  root;
  } sqrt_st_t;

  // per-lane division work state
  typedef struct packed {
    logic [ProdWidth-1:0] rem;
    logic [8:0]           quo;
    logic                 neg;
  } div_st_t;

endpackage

// ===== hw/rtl/snrp_sqrt.sv =====
// Pipelined digit-by-digit square root: one root bit per stage, full stall support.
module snrp_sqrt (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       en,
  input  logic                                       in_valid,
  input  logic [snrp_pkg::RadWidth-1:0]              in_rad,
  input  logic [3*snrp_pkg::GradWidth+2*snrp_pkg::CoordWidth-1:0] in_side,
  output logic                                       out_valid,
  output logic [snrp_pkg::RootWidth-1:0]             out_root,
  output logic [3*snrp_pkg::GradWidth+2*snrp_pkg::CoordWidth-1:0] out_side
);
  import snrp_pkg::*;

  sqrt_st_t                                       st    [RootSteps+1];
  logic     [RootSteps:0]                         vld;
  logic     [3*GradWidth+2*CoordWidth-1:0]        side  [RootSteps+1];

  assign st[0].rad  = in_rad;
  assign st[0].rem  = '0;
  assign st[0].root = '0;
  assign vld[0]     = in_valid;
  assign side[0]    = in_side;

  for (genvar i = 0; i < RootSteps; i++) begin : g_step
    sqrt_st_t nx;
    logic [RootWidth+1:0] trial;
    logic [RootWidth+1:0] shifted;
    always_comb begin
      shifted = {st[i].rem[RootWidth-1:0], st[i].rad[RadWidth-1 -: 2]};
      trial   = {st[i].root, 2'b01};
      nx.rad  = {st[i].rad[RadWidth-3:0], 2'b00};
      if (shifted >= trial) begin
        nx.rem  = shifted - trial;
        nx.root = {st[i].root[RootWidth-2:0], 1'b1};
      end else begin
        nx.rem  = shifted;
        nx.root = {st[i].root[RootWidth-2:0], 1'b0};
      end
    end
    sqrt_st_t                              st_q;
    logic [3*GradWidth+2*CoordWidth-1:0]   side_q;
    logic                                  vld_q;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_q   <= nx;
        side_q <= side[i];
      end
    end
    assign st[i+1]   = st_q;
    assign vld[i+1]  = vld_q;
    assign side[i+1] = side_q;
  end

  assign out_valid = vld[RootSteps];
  assign out_root  = st[RootSteps].root;
  assign out_side  = side[RootSteps];

endmodule

// ===== hw/rtl/snrp_byte_div.sv =====
// Pipelined restoring divide of 255*num by 2*len, nine quotient bits, one per stage.
module snrp_byte_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [snrp_pkg::GradWidth-1:0]  in_grad,
  input  logic [snrp_pkg::RootWidth-1:0]  in_len,
  output logic                            out_valid,
  output logic [7:0]                      out_byte
);
  import snrp_pkg::*;

  // setup stage: form 255*num and the clamp flags
  logic [NumWidth-1:0]  num;
  logic signed [NumWidth:0] snum;
  logic                 s_vld;
  logic [ProdWidth-1:0] s_prod;
  logic [RootWidth:0]   s_den;
  logic                 s_neg;
  logic                 s_zero;

  always_comb begin
    snum = NumWidth'(signed'(in_grad)) * (NumWidth+1)'(256)
         + (NumWidth+1)'({1'b0, in_len});
    num  = snum[NumWidth-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else if (en) begin
      s_vld <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s_prod <= ProdWidth'({num, 8'd0}) - ProdWidth'(num);
      s_den  <= {in_len, 1'b0};
      s_neg  <= snum[NumWidth] || (snum == '0);
      s_zero <= (in_len == '0);
    end
  end

  // quotient < 512, so nine shifted compares settle it
  div_st_t              st   [DivSteps+1];
  logic [DivSteps:0]    vld;
  logic [RootWidth:0]   den  [DivSteps+1];
  logic [DivSteps:0]    zr;

  assign st[0].rem = s_prod;
  assign st[0].quo = '0;
  assign st[0].neg = s_neg;
  assign vld[0]    = s_vld;
  assign den[0]    = s_den;
  assign zr[0]     = s_zero;

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    localparam int Sh = DivSteps - 1 - i;
    div_st_t nx;
    logic [ProdWidth+8:0] dsh;
    always_comb begin
      dsh    = (ProdWidth+9)'(den[i]) << Sh;
      nx     = st[i];
      if ((ProdWidth+9)'(st[i].rem) >= dsh) begin
        nx.rem    = st[i].rem - dsh[ProdWidth-1:0];
        nx.quo[Sh] = 1'b1;
      end
    end
    div_st_t            st_q;
    logic               vld_q;
    logic [RootWidth:0] den_q;
    logic               zr_q;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_q  <= nx;
        den_q <= den[i];
        zr_q  <= zr[i];
      end
    end
    assign st[i+1]  = st_q;
    assign vld[i+1] = vld_q;
    assign den[i+1] = den_q;
    assign zr[i+1]  = zr_q;
  end

  // zero vector, non-positive numerator, overflow clamp
  always_comb begin
    if (zr[DivSteps]) begin
      out_byte = ZeroByte;
    end else if (st[DivSteps].neg) begin
      out_byte = 8'd0;
    end else if (st[DivSteps].quo[8]) begin
      out_byte = 8'd255;
    end else begin
      out_byte = st[DivSteps].quo[7:0];
    end
  end
  assign out_valid = vld[DivSteps];

endmodule

// ===== hw/rtl/surface_normal_rgba_packer.sv =====
// Channel | dir | tdata (low bit up)                                  | handshake
// s_axis  | in  | grad_x 24, grad_y 24, grad_z 24, pixel_col 12, pixel_row 12 | tvalid/tready
// m_axis  | out | out_col 12, out_row 12, packed_rgba 32              | tvalid/tready
//
// One item per cycle unless stalled; stages are magnitudes, squares, root, divide, output.
// The root pipeline retires one bit per stage; the three byte dividers run in parallel.
// rst is synchronous and clears only the valid bits; payload registers are not reset.
// The whole pipeline advances when the output register is empty or being taken;
// a stall freezes every stage, so nothing is lost or repeated.
module surface_normal_rgba_packer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // grad_x[23:0], grad_y[47:24], grad_z[71:48], pixel_col[83:72], pixel_row[95:84]
  input  logic [snrp_pkg::InBytes*8-1:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_col[11:0], out_row[23:12], packed_rgba[55:24]
  output logic [snrp_pkg::OutBytes*8-1:0] m_axis_tdata
);
  import snrp_pkg::*;

  localparam int SideWidth = 3 * GradWidth + 2 * CoordWidth;

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: magnitudes
  logic                      v1;
  logic [SideWidth-1:0]      side1;
  logic [MagWidth-1:0]       mag1 [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= s_axis_tdata[SideWidth-1:0];
      for (int k = 0; k < 3; k++) begin
        mag1[k] <= s_axis_tdata[k*GradWidth+GradWidth-1] ?
                   MagWidth'(-s_axis_tdata[k*GradWidth +: GradWidth]) :
                   s_axis_tdata[k*GradWidth +: GradWidth];
      end
    end
  end

  // stage 2: squares
  logic                 v2;
  logic [SideWidth-1:0] side2;
  logic [SqWidth-1:0]   sq2 [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side2 <= side1;
      for (int k = 0; k < 3; k++) begin
        sq2[k] <= mag1[k] * mag1[k];
      end
    end
  end

  // sum of squares scaled by 65536 feeds the root pipeline
  logic [SumWidth-1:0] sum2;
  assign sum2 = SumWidth'(sq2[0]) + SumWidth'(sq2[1]) + SumWidth'(sq2[2]);

  logic                 v3;
  logic [RootWidth-1:0] len3;
  logic [SideWidth-1:0] side3;
  snrp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .in_rad    ({sum2, 16'd0}),
    .in_side   (side2),
    .out_valid (v3),
    .out_root  (len3),
    .out_side  (side3)
  );

  // side data delay matching the divider depth
  localparam int DivLat = DivSteps + 1;
  logic [2*CoordWidth-1:0] cdly [DivLat+1];
  assign cdly[0] = side3[3*GradWidth +: 2*CoordWidth];
  for (genvar d = 0; d < DivLat; d++) begin : g_dly
    logic [2*CoordWidth-1:0] q;
    always_ff @(posedge clk) begin
      if (en) begin
        q <= cdly[d];
      end
    end
    assign cdly[d+1] = q;
  end

  logic [2:0] vd;
  logic [7:0] bytes [3];
  for (genvar k = 0; k < 3; k++) begin : g_lane
    snrp_byte_div u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v3),
      .in_grad   (side3[k*GradWidth +: GradWidth]),
      .in_len    (len3),
      .out_valid (vd[k]),
      .out_byte  (bytes[k])
    );
  end

  // output register
  logic [OutWidth-1:0] out_word;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vd[0];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= {AlphaByte, bytes[2], bytes[1], bytes[0], cdly[DivLat]};
    end
  end
  assign m_axis_tdata = (OutBytes*8)'(out_word);

  // lanes stay in lockstep
  assert property (@(posedge clk) disable iff (rst) vd[0] == vd[1] && vd[1] == vd[2])
    else $error("divider lanes out of step");
  // a stalled result keeps its data
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  // alpha byte is constant
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2*CoordWidth+24 +: 8] == AlphaByte)
    else $error("alpha byte wrong");

endmodule
